// ===== hdl/nec_ir_pkg.sv =====
// shared constants, types and segment length tables for the nec ir frame transmitter
// no dependencies
`default_nettype none

package nec_ir_pkg;

    localparam int PAYLOAD_BITS_DEF = 32;
    localparam int DATA_W = 32;
    localparam int TICKS_W = 8;
    localparam int PHASE_W = 22;
    localparam int SEG_W = 6;
    localparam int US_W = 14;

    localparam int HDR1_PERIOD_US = 9560;
    localparam int HDR1_SPACE_US = 560;
    localparam int HDR2_PERIOD_US = 5060;
    localparam int HDR2_SPACE_US = 4500;
    localparam int ONE_PERIOD_US = 2240;
    localparam int ONE_SPACE_US = 1680;
    localparam int ZERO_PERIOD_US = 1120;
    localparam int ZERO_SPACE_US = 560;
    localparam int HDR_SEGMENTS = 2;

    localparam logic [TICKS_W-1:0] TICKS_RESET = TICKS_W'(3);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_IDX_TICKS = 1'b0;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef struct packed {
        logic ir_mark;
        logic busy_res;
        logic frame_done;
    } nec_ir_result_t;

    function automatic logic [US_W-1:0] space_us(input logic [SEG_W-1:0] seg, input logic bit_v);
        logic [US_W-1:0] r;
        if (seg == SEG_W'(0))
            r = US_W'(HDR1_SPACE_US);
        else if (seg == SEG_W'(1))
            r = US_W'(HDR2_SPACE_US);
        else if (bit_v)
            r = US_W'(ONE_SPACE_US);
        else
            r = US_W'(ZERO_SPACE_US);
        return r;
    endfunction

    function automatic logic [US_W-1:0] mark_us(input logic [SEG_W-1:0] seg, input logic bit_v);
        logic [US_W-1:0] r;
        if (seg == SEG_W'(0))
            r = US_W'(HDR1_PERIOD_US - HDR1_SPACE_US);
        else if (seg == SEG_W'(1))
            r = US_W'(HDR2_PERIOD_US - HDR2_SPACE_US);
        else if (bit_v)
            r = US_W'(ONE_PERIOD_US - ONE_SPACE_US);
        else
            r = US_W'(ZERO_PERIOD_US - ZERO_SPACE_US);
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/nec_ir_if.sv =====
// request channels of the nec ir frame transmitter: input items and result items
// depends on nec_ir_pkg
`default_nettype none

interface nec_ir_in_if;
    logic valid;
    logic ready;
    logic command;
    logic [nec_ir_pkg::DATA_W-1:0] data_word;

    modport source (output valid, output command, output data_word, input ready);
    modport sink (input valid, input command, input data_word, output ready);
endinterface

interface nec_ir_out_if;
    logic valid;
    logic ready;
    logic ir_mark;
    logic busy_res;
    logic frame_done;

    modport source (output valid, output ir_mark, output busy_res, output frame_done,
                    input ready);
    modport sink (input valid, input ir_mark, input busy_res, input frame_done,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/nec_ir_core.sv =====
// frame sequencer: segment counter, phase timer and payload shifter, one step per request
// depends on nec_ir_pkg
`default_nettype none

module nec_ir_core #(
    parameter int PAYLOAD_BITS = nec_ir_pkg::PAYLOAD_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               step,
    input  wire logic                               command,
    input  wire logic [nec_ir_pkg::DATA_W-1:0]      data_word,
    input  wire logic [nec_ir_pkg::TICKS_W-1:0]     ticks_per_us,
    output nec_ir_pkg::nec_ir_result_t              result
);
    import nec_ir_pkg::*;

    localparam logic [SEG_W-1:0] SEGMENTS = SEG_W'(HDR_SEGMENTS + PAYLOAD_BITS);

    logic [PHASE_W-1:0]      phase_ticks_left_reg, phase_ticks_left_next;
    logic [SEG_W-1:0]        segment_index_reg, segment_index_next;
    logic                    in_mark_phase_reg, in_mark_phase_next;
    logic [PAYLOAD_BITS-1:0] payload_shift_reg, payload_shift_next;
    logic                    sending_reg, sending_next;

    logic [PHASE_W-1:0]      dec;
    logic [SEG_W-1:0]        seg_inc;
    logic [US_W-1:0]         us_sel;
    logic [PHASE_W-1:0]      product;
    logic [PHASE_W-1:0]      scaled;

    assign dec = phase_ticks_left_reg - PHASE_W'(1);
    assign seg_inc = segment_index_reg + SEG_W'(1);
    assign product = PHASE_W'(ticks_per_us) * PHASE_W'(us_sel);
    assign scaled = (product == '0) ? PHASE_W'(1) : product;

    always_comb
    begin
        phase_ticks_left_next = phase_ticks_left_reg;
        segment_index_next = segment_index_reg;
        in_mark_phase_next = in_mark_phase_reg;
        payload_shift_next = payload_shift_reg;
        sending_next = sending_reg;
        result = '0;
        us_sel = US_W'(HDR1_SPACE_US);
        if (command == CMD_START)
        begin
            payload_shift_next = data_word[PAYLOAD_BITS-1:0];
            segment_index_next = '0;
            sending_next = 1'b1;
            in_mark_phase_next = 1'b0;
            phase_ticks_left_next = scaled;
            result.busy_res = 1'b1;
        end
        else if (sending_reg)
        begin
            result.busy_res = 1'b1;
            result.ir_mark = in_mark_phase_reg;
            phase_ticks_left_next = dec;
            if (dec == '0)
            begin
                if (!in_mark_phase_reg)
                begin
                    us_sel = mark_us(segment_index_reg, payload_shift_reg[PAYLOAD_BITS-1]);
                    in_mark_phase_next = 1'b1;
                    phase_ticks_left_next = scaled;
                end
                else
                begin
                    if (segment_index_reg >= SEG_W'(HDR_SEGMENTS))
                        payload_shift_next = payload_shift_reg << 1;
                    segment_index_next = seg_inc;
                    in_mark_phase_next = 1'b0;
                    us_sel = space_us(seg_inc, payload_shift_next[PAYLOAD_BITS-1]);
                    if (seg_inc >= SEGMENTS)
                    begin
                        sending_next = 1'b0;
                        segment_index_next = '0;
                        result.frame_done = 1'b1;
                    end
                    else
                    begin
                        phase_ticks_left_next = scaled;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_left_reg <= '0;
            segment_index_reg <= '0;
            in_mark_phase_reg <= 1'b0;
            payload_shift_reg <= '0;
            sending_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_ticks_left_reg <= phase_ticks_left_next;
            segment_index_reg <= segment_index_next;
            in_mark_phase_reg <= in_mark_phase_next;
            payload_shift_reg <= payload_shift_next;
            sending_reg <= sending_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/nec_ir_frame_transmitter_unit.sv =====
// top level of the nec ir frame transmitter: apb register, input register, result register
// depends on nec_ir_pkg, nec_ir_if and nec_ir_core
`default_nettype none

// Each input request is either a start (latch a data word, begin a frame) or one timer
// tick, and yields exactly one result: the envelope level of that tick, a busy flag and
// a frame-done flag. A new request is taken every clock while results are taken; a request
// passes through the input register, then the sequencer step into the result register.
// A frame is a header space/mark pair (560/9000 us), a second pair (4500/560 us) and one
// pair per payload bit, msb first (1680 or 560 us space, 560 us mark), each length
// scaled by ticks_per_us, register 0 at byte address 0 (reset 3). A start while busy
// restarts the frame.

module nec_ir_frame_transmitter_unit #(
    parameter int PAYLOAD_BITS = nec_ir_pkg::PAYLOAD_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    nec_ir_in_if.sink                                in_chan,
    nec_ir_out_if.source                             out_chan,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [nec_ir_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [nec_ir_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [nec_ir_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                     pready
);
    import nec_ir_pkg::*;

    logic [TICKS_W-1:0] ticks_reg;
    logic               stage_valid_reg;
    logic               stage_command_reg;
    logic [DATA_W-1:0]  stage_data_reg;
    logic               out_valid_reg;
    nec_ir_result_t     out_result_reg;
    nec_ir_result_t     core_result;
    logic               out_free;
    logic               stage_free;
    logic               step;

    assign pready = 1'b1;
    assign prdata = (paddr[APB_ADDR_W-1] == REG_IDX_TICKS)
                    ? APB_DATA_W'(ticks_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ticks_reg <= TICKS_RESET;
        else if (psel && penable && pwrite && pready && paddr[APB_ADDR_W-1] == REG_IDX_TICKS)
            ticks_reg <= pwdata[TICKS_W-1:0];
    end

    assign out_free = !out_valid_reg || out_chan.ready;
    assign step = stage_valid_reg && out_free;
    assign stage_free = !stage_valid_reg || out_free;
    assign in_chan.ready = stage_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (stage_free)
            stage_valid_reg <= in_chan.valid;
    end

    always_ff @(posedge clk)
    begin
        if (stage_free && in_chan.valid)
        begin
            stage_command_reg <= in_chan.command;
            stage_data_reg <= in_chan.data_word;
        end
    end

    nec_ir_core #(
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .command      (stage_command_reg),
        .data_word    (stage_data_reg),
        .ticks_per_us (ticks_reg),
        .result       (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= stage_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_result_reg <= core_result;
    end

    assign out_chan.valid = out_valid_reg;
    assign out_chan.ir_mark = out_result_reg.ir_mark;
    assign out_chan.busy_res = out_result_reg.busy_res;
    assign out_chan.frame_done = out_result_reg.frame_done;

endmodule

`default_nettype wire
